### rtl/pesc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the per-source event statistics checker
// no dependencies; used by the top level

package pesc_pkg;

  // table geometry
  localparam int MAX_SOURCES = 64;
  localparam int SRC_IDX_W   = $clog2(MAX_SOURCES);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_WORDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;
  localparam int CFG_DATA_W = 32;

  // validation levels
  localparam logic [1:0] LEVEL_STRICT = 2'd2;

  // configuration reset values
  localparam logic [1:0]  LEVEL_RESET     = 2'd0;
  localparam logic [31:0] HDR_WORDS_RESET = 32'd8;
  localparam logic [7:0]  VERSION_RESET   = 8'd6;

  // problem codes
  localparam logic [2:0] PROB_NONE      = 3'd0;
  localparam logic [2:0] PROB_PARSE     = 3'd1;
  localparam logic [2:0] PROB_HDR_LEN   = 3'd2;
  localparam logic [2:0] PROB_VERSION   = 3'd3;
  localparam logic [2:0] PROB_TIME_BACK = 3'd4;
  localparam logic [2:0] PROB_FRAME_GAP = 3'd5;

  // one input event
  typedef struct packed {
    logic [5:0]  source_index;
    logic [23:0] event_size;
    logic        parse_ok;
    logic [31:0] header_words;
    logic [7:0]  format_version;
    logic [63:0] event_time;
    logic [15:0] origin_id;
    logic [31:0] frame_number;
  } item_t;

  // one per-source table entry
  typedef struct packed {
    logic [31:0] events;
    logic [47:0] bytes;
    logic [31:0] malformed;
    logic [23:0] min_size;
    logic [23:0] max_size;
    logic [31:0] regressions;
    logic [31:0] gaps;
    logic [63:0] last_time;
    logic [15:0] origin;
    logic        origin_stable;
    logic        seen_time;
    logic [31:0] last_frame;
    logic        seen_frame;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // value of an entry that was never written
  localparam entry_t ENTRY_RESET = '{
    events:        32'd0,
    bytes:         48'd0,
    malformed:     32'd0,
    min_size:      24'd0,
    max_size:      24'd0,
    regressions:   32'd0,
    gaps:          32'd0,
    last_time:     64'd0,
    origin:        16'd0,
    origin_stable: 1'b1,
    seen_time:     1'b0,
    last_frame:    32'd0,
    seen_frame:    1'b0
  };

endpackage

### rtl/pesc_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module pesc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/per_source_event_stats_checker.sv
`timescale 1ns / 1ps
// A result passes the stage 1 and output registers before it is offered.
// Throughput: one event per cycle unless the output stalls, set by the
// per-source table ram, read on accept, written back with a one-deep bypass.
// Reset (rst, synchronous): configuration returns to its defaults, totals
// clear and per-entry valid flags clear, so every entry reads as cleared;
// no clearing pass is needed. Depends on pesc_pkg and pesc_ram.

module per_source_event_stats_checker (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pesc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pesc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [5:0]                       source_index,
  input  logic [23:0]                      event_size,
  input  logic                             parse_ok,
  input  logic [31:0]                      header_words,
  input  logic [7:0]                       format_version,
  input  logic [63:0]                      event_time,
  input  logic [15:0]                      origin_id,
  input  logic [31:0]                      frame_number,
  // result output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             accepted,
  output logic [2:0]                       problem_code,
  output logic [31:0]                      total_events,
  output logic [47:0]                      total_bytes,
  output logic [31:0]                      src_events,
  output logic [47:0]                      src_bytes,
  output logic [31:0]                      src_malformed,
  output logic [23:0]                      src_min_size,
  output logic [23:0]                      src_max_size,
  output logic [31:0]                      src_regressions,
  output logic [31:0]                      src_gaps,
  output logic                             src_id_stable
);

  import pesc_pkg::*;

  // saturating helpers
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] v, input logic [23:0] a);
    logic [48:0] s;
    s = {1'b0, v} + {25'd0, a};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  // configuration registers
  logic [1:0]  validation_level;
  logic [31:0] expected_header_words;
  logic [7:0]  expected_version;

  // pipeline and table control
  logic                   in_accept;
  logic                   s1_valid;
  logic                   s1_advance;
  item_t                  s1_item;
  logic [SRC_IDX_W-1:0]   in_idx;
  logic [SRC_IDX_W-1:0]   s1_idx;
  logic [MAX_SOURCES-1:0] entry_valid;
  logic                   fwd_hit;
  entry_t                 fwd_data;
  logic [ENTRY_W-1:0]     ram_rd;
  entry_t                 cur;
  entry_t                 entry_next;
  logic [2:0]             code_next;

  // grand totals
  logic [31:0] grand_events;
  logic [47:0] grand_bytes;
  logic [31:0] grand_events_next;
  logic [47:0] grand_bytes_next;

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      validation_level      <= LEVEL_RESET;
      expected_header_words <= HDR_WORDS_RESET;
      expected_version      <= VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEVEL:     validation_level      <= cfg_data[1:0];
        CFG_HDR_WORDS: expected_header_words <= cfg_data;
        CFG_VERSION:   expected_version      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or drains
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;
  assign in_idx     = source_index[SRC_IDX_W-1:0];
  assign s1_idx     = s1_item.source_index[SRC_IDX_W-1:0];

  // per-source table
  pesc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SOURCES)
  ) u_table (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_idx),
    .wr_data (entry_next),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (ram_rd)
  );

  // stage 1 input register, bypass capture and entry valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_advance && (s1_idx == in_idx);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        entry_valid[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item  <= '{source_index, event_size, parse_ok, header_words,
                    format_version, event_time, origin_id, frame_number};
      fwd_data <= entry_next;
    end
  end

  // current entry: bypassed write, stored value, or cleared value
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (entry_valid[s1_idx]) begin
      cur = entry_t'(ram_rd);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  // entry update and classification
  always_comb begin
    logic strict;
    logic regressed;
    logic gapped;
    logic [15:0] origin_ref;
    strict     = (validation_level == LEVEL_STRICT);
    regressed  = 1'b0;
    gapped     = 1'b0;
    origin_ref = cur.origin;
    entry_next = cur;
    code_next  = PROB_NONE;

    // size statistics, always updated
    entry_next.events = sat_inc32(cur.events);
    entry_next.bytes  = sat_add48(cur.bytes, s1_item.event_size);
    if ((cur.min_size == 24'd0) || (s1_item.event_size < cur.min_size)) begin
      entry_next.min_size = s1_item.event_size;
    end
    if (s1_item.event_size > cur.max_size) begin
      entry_next.max_size = s1_item.event_size;
    end

    if (!s1_item.parse_ok) begin
      code_next = PROB_PARSE;
    end else if (strict && (s1_item.header_words != expected_header_words)) begin
      code_next = PROB_HDR_LEN;
    end else if (strict && (s1_item.format_version != expected_version)) begin
      code_next = PROB_VERSION;
    end else begin
      // timestamp and origin tracking
      if (!cur.seen_time) begin
        origin_ref           = s1_item.origin_id;
        entry_next.origin    = s1_item.origin_id;
        entry_next.seen_time = 1'b1;
      end else if (s1_item.event_time < cur.last_time) begin
        entry_next.regressions = sat_inc32(cur.regressions);
        regressed              = 1'b1;
      end
      entry_next.last_time = s1_item.event_time;
      if (s1_item.origin_id != origin_ref) begin
        entry_next.origin_stable = 1'b0;
      end
      // frame counter continuity, wraps at 32 bits
      if (cur.seen_frame && (s1_item.frame_number != cur.last_frame + 32'd1)) begin
        entry_next.gaps = sat_inc32(cur.gaps);
        gapped          = 1'b1;
      end
      entry_next.last_frame = s1_item.frame_number;
      entry_next.seen_frame = 1'b1;
      if (strict && regressed) begin
        code_next = PROB_TIME_BACK;
      end else if (strict && gapped) begin
        code_next = PROB_FRAME_GAP;
      end
    end

    if (code_next != PROB_NONE) begin
      entry_next.malformed = sat_inc32(cur.malformed);
    end
  end

  // grand totals
  assign grand_events_next = sat_inc32(grand_events);
  assign grand_bytes_next  = sat_add48(grand_bytes, s1_item.event_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      grand_events <= 32'd0;
      grand_bytes  <= 48'd0;
    end else if (s1_advance) begin
      grand_events <= grand_events_next;
      grand_bytes  <= grand_bytes_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      accepted        <= (code_next == PROB_NONE);
      problem_code    <= code_next;
      total_events    <= grand_events_next;
      total_bytes     <= grand_bytes_next;
      src_events      <= entry_next.events;
      src_bytes       <= entry_next.bytes;
      src_malformed   <= entry_next.malformed;
      src_min_size    <= entry_next.min_size;
      src_max_size    <= entry_next.max_size;
      src_regressions <= entry_next.regressions;
      src_gaps        <= entry_next.gaps;
      src_id_stable   <= entry_next.origin_stable;
    end
  end

`ifndef SYNTH
  // a source never counts more events than the grand total
  a_src_within_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (src_events <= total_events))
    else $error("source event count exceeds grand total");

  // rejected events are a subset of the events of that source
  a_malformed_within_events: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (src_malformed <= src_events))
    else $error("malformed count exceeds source event count");

  // a set minimum never lies above the maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (src_min_size != 24'd0)) |-> (src_min_size <= src_max_size))
    else $error("minimum size above maximum size");

  // the accept flag agrees with the problem code
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (problem_code == PROB_NONE)))
    else $error("accept flag disagrees with problem code");

  // no beat is taken while stage 1 is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> !in_accept)
    else $error("event taken while stage 1 is blocked");
`endif

endmodule

### test/per_source_event_stats_checker_mon.sv
`timescale 1ns / 1ps
// scoreboard for the per-source event statistics checker: watches the config,
// event and result channels, predicts each result and compares it field by field
// depends on pesc_pkg; instantiated by per_source_event_stats_checker_tb

module per_source_event_stats_checker_mon (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pesc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pesc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event channel
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  pesc_pkg::item_t                  offer,
  // result channel
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             accepted,
  input  logic [2:0]                       problem_code,
  input  logic [31:0]                      total_events,
  input  logic [47:0]                      total_bytes,
  input  logic [31:0]                      src_events,
  input  logic [47:0]                      src_bytes,
  input  logic [31:0]                      src_malformed,
  input  logic [23:0]                      src_min_size,
  input  logic [23:0]                      src_max_size,
  input  logic [31:0]                      src_regressions,
  input  logic [31:0]                      src_gaps,
  input  logic                             src_id_stable,
  // status towards the testbench top
  output int                               fails,
  output int                               pending,
  output int                               checked,
  output int                               rejected
);

  import pesc_pkg::*;

  // one result beat
  typedef struct packed {
    logic        accepted;
    logic [2:0]  code;
    logic [31:0] total_events;
    logic [47:0] total_bytes;
    logic [31:0] events;
    logic [47:0] bytes;
    logic [31:0] malformed;
    logic [23:0] min_size;
    logic [23:0] max_size;
    logic [31:0] regressions;
    logic [31:0] gaps;
    logic        id_stable;
  } src_report_t;

  // predicted configuration and table
  logic [1:0]  mode_level;
  logic [31:0] want_hdr_words;
  logic [7:0]  want_version;
  logic [31:0] grand_events;
  logic [47:0] grand_bytes;
  entry_t      src_table [MAX_SOURCES];
  src_report_t report_q [$];

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] v, input logic [23:0] a);
    logic [48:0] s;
    s = {1'b0, v} + {25'd0, a};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // update the table with one event and return the report it produces
  function automatic src_report_t tally_event(input item_t ev);
    int          e;
    entry_t      en;
    logic        strict;
    logic        back;
    logic        gap;
    logic [2:0]  code;
    src_report_t r;
    e      = int'(ev.source_index) % MAX_SOURCES;
    en     = src_table[e];
    strict = (mode_level == LEVEL_STRICT);
    back   = 1'b0;
    gap    = 1'b0;
    code   = PROB_NONE;

    // sizes and counts move on every event
    grand_events = bump32(grand_events);
    grand_bytes  = add48(grand_bytes, ev.event_size);
    en.events    = bump32(en.events);
    en.bytes     = add48(en.bytes, ev.event_size);
    if (en.min_size == 24'd0 || ev.event_size < en.min_size) en.min_size = ev.event_size;
    if (ev.event_size > en.max_size) en.max_size = ev.event_size;

    // rejection order: parse, header length, version, then sequence checks
    if (!ev.parse_ok) begin
      code = PROB_PARSE;
    end else if (strict && ev.header_words != want_hdr_words) begin
      code = PROB_HDR_LEN;
    end else if (strict && ev.format_version != want_version) begin
      code = PROB_VERSION;
    end else begin
      if (!en.seen_time) begin
        en.origin    = ev.origin_id;
        en.seen_time = 1'b1;
      end else if (ev.event_time < en.last_time) begin
        en.regressions = bump32(en.regressions);
        back = 1'b1;
      end
      en.last_time = ev.event_time;
      if (ev.origin_id != en.origin) en.origin_stable = 1'b0;
      // frame counter wraps at 32 bits
      if (en.seen_frame && ev.frame_number != en.last_frame + 32'd1) begin
        en.gaps = bump32(en.gaps);
        gap = 1'b1;
      end
      en.last_frame = ev.frame_number;
      en.seen_frame = 1'b1;
      if (strict && back) code = PROB_TIME_BACK;
      else if (strict && gap) code = PROB_FRAME_GAP;
    end

    if (code != PROB_NONE) en.malformed = bump32(en.malformed);
    src_table[e] = en;

    r.accepted     = (code == PROB_NONE);
    r.code         = code;
    r.total_events = grand_events;
    r.total_bytes  = grand_bytes;
    r.events       = en.events;
    r.bytes        = en.bytes;
    r.malformed    = en.malformed;
    r.min_size     = en.min_size;
    r.max_size     = en.max_size;
    r.regressions  = en.regressions;
    r.gaps         = en.gaps;
    r.id_stable    = en.origin_stable;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fails++;
    end
  endtask

  // one process: config, result compare, then event prediction
  always @(posedge clk) begin
    src_report_t w;
    if (rst) begin
      mode_level     = LEVEL_RESET;
      want_hdr_words = HDR_WORDS_RESET;
      want_version   = VERSION_RESET;
      grand_events   = 32'd0;
      grand_bytes    = 48'd0;
      for (int i = 0; i < MAX_SOURCES; i++) src_table[i] = ENTRY_RESET;
      report_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL:     mode_level = cfg_data[1:0];
          CFG_HDR_WORDS: want_hdr_words = cfg_data[31:0];
          CFG_VERSION:   want_version = cfg_data[7:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $display("%0t: result beat with no event outstanding, expected none, actual code %0d",
                   $time, problem_code);
          fails++;
        end else begin
          w = report_q.pop_front();
          check_field("accepted", 64'(w.accepted), 64'(accepted));
          check_field("problem_code", 64'(w.code), 64'(problem_code));
          check_field("total_events", 64'(w.total_events), 64'(total_events));
          check_field("total_bytes", 64'(w.total_bytes), 64'(total_bytes));
          check_field("src_events", 64'(w.events), 64'(src_events));
          check_field("src_bytes", 64'(w.bytes), 64'(src_bytes));
          check_field("src_malformed", 64'(w.malformed), 64'(src_malformed));
          check_field("src_min_size", 64'(w.min_size), 64'(src_min_size));
          check_field("src_max_size", 64'(w.max_size), 64'(src_max_size));
          check_field("src_regressions", 64'(w.regressions), 64'(src_regressions));
          check_field("src_gaps", 64'(w.gaps), 64'(src_gaps));
          check_field("src_id_stable", 64'(w.id_stable), 64'(src_id_stable));
          checked++;
          if (!w.accepted) rejected++;
        end
      end

      // event beat
      if (in_valid && !in_stall) report_q.push_back(tally_event(offer));
    end
    pending = report_q.size();
  end

endmodule

### test/per_source_event_stats_checker_tb.sv
`timescale 1ns / 1ps
// testbench top for the per-source event statistics checker: clock, reset,
// event and config stimulus, random back-pressure and the final verdict
// depends on pesc_pkg, the block and per_source_event_stats_checker_mon

module per_source_event_stats_checker_tb;

  import pesc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 190;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  item_t                 offer;
  logic                  out_valid;
  logic                  out_stall;
  logic                  accepted;
  logic [2:0]            problem_code;
  logic [31:0]           total_events;
  logic [47:0]           total_bytes;
  logic [31:0]           src_events;
  logic [47:0]           src_bytes;
  logic [31:0]           src_malformed;
  logic [23:0]           src_min_size;
  logic [23:0]           src_max_size;
  logic [31:0]           src_regressions;
  logic [31:0]           src_gaps;
  logic                  src_id_stable;

  int fails;
  int pending;
  int checked;
  int rejected;

  // stimulus-side view of each source, used to shape well-formed sequences
  logic [63:0] trk_time   [MAX_SOURCES];
  logic [31:0] trk_frame  [MAX_SOURCES];
  logic [15:0] trk_origin [MAX_SOURCES];
  logic [1:0]  cur_level;
  logic [31:0] cur_hdr;
  logic [7:0]  cur_ver;

  logic jitter_on;
  logic hold_req;
  int   sent;
  int   directed;
  int   quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  per_source_event_stats_checker u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .source_index    (offer.source_index),
    .event_size      (offer.event_size),
    .parse_ok        (offer.parse_ok),
    .header_words    (offer.header_words),
    .format_version  (offer.format_version),
    .event_time      (offer.event_time),
    .origin_id       (offer.origin_id),
    .frame_number    (offer.frame_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .problem_code    (problem_code),
    .total_events    (total_events),
    .total_bytes     (total_bytes),
    .src_events      (src_events),
    .src_bytes       (src_bytes),
    .src_malformed   (src_malformed),
    .src_min_size    (src_min_size),
    .src_max_size    (src_max_size),
    .src_regressions (src_regressions),
    .src_gaps        (src_gaps),
    .src_id_stable   (src_id_stable)
  );

  per_source_event_stats_checker_mon u_mon (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .offer           (offer),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .problem_code    (problem_code),
    .total_events    (total_events),
    .total_bytes     (total_bytes),
    .src_events      (src_events),
    .src_bytes       (src_bytes),
    .src_malformed   (src_malformed),
    .src_min_size    (src_min_size),
    .src_max_size    (src_max_size),
    .src_regressions (src_regressions),
    .src_gaps        (src_gaps),
    .src_id_stable   (src_id_stable),
    .fails           (fails),
    .pending         (pending),
    .checked         (checked),
    .rejected        (rejected)
  );

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= jitter_on && ($urandom_range(99) < 7);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t pin_event(input logic [5:0] src, input logic [23:0] size,
                                      input logic ok, input logic [31:0] hdr,
                                      input logic [7:0] ver, input logic [63:0] t,
                                      input logic [15:0] org, input logic [31:0] frm);
    item_t ev;
    ev.source_index   = src;
    ev.event_size     = size;
    ev.parse_ok       = ok;
    ev.header_words   = hdr;
    ev.format_version = ver;
    ev.event_time     = t;
    ev.origin_id      = org;
    ev.frame_number   = frm;
    return ev;
  endfunction

  // mostly in-sequence events on a few sources, with some noise
  function automatic item_t roll_event();
    item_t ev;
    int    s;
    int    pick;
    s    = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(MAX_SOURCES - 1);
    ev.source_index = s[5:0];
    pick = $urandom_range(99);
    if (pick < 10)      ev.event_size = 24'd0;
    else if (pick < 18) ev.event_size = 24'hFF_FFFF;
    else if (pick < 38) ev.event_size = 24'($urandom());
    else                ev.event_size = 24'($urandom_range(4000, 1));
    ev.parse_ok       = ($urandom_range(99) < 94);
    ev.header_words   = ($urandom_range(99) < 92) ? cur_hdr : $urandom();
    ev.format_version = ($urandom_range(99) < 92) ? cur_ver : 8'($urandom());
    pick = $urandom_range(99);
    if (pick < 85)      ev.event_time = trk_time[s] + 64'($urandom_range(1000));
    else if (pick < 93) ev.event_time = trk_time[s] - 64'($urandom_range(1000, 1));
    else                ev.event_time = {$urandom(), $urandom()};
    ev.origin_id = ($urandom_range(99) < 96) ? trk_origin[s] : 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 88)      ev.frame_number = trk_frame[s] + 32'd1;
    else if (pick < 94) ev.frame_number = trk_frame[s] + 32'($urandom_range(5, 2));
    else                ev.frame_number = $urandom();
    return ev;
  endfunction

  task automatic send_event(input item_t ev);
    @(negedge clk);
    while (jitter_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    offer    <= ev;
    do @(posedge clk); while (in_stall);
    trk_time[ev.source_index]  = ev.event_time;
    trk_frame[ev.source_index] = ev.frame_number;
    sent++;
  endtask

  // drop valid and wait until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // write all three registers; unused upper data bits carry noise
  task automatic set_config(input logic [1:0] level, input logic [31:0] hdr,
                            input logic [7:0] ver);
    logic [31:0] lvl_word;
    logic [31:0] ver_word;
    lvl_word      = $urandom();
    lvl_word[1:0] = level;
    ver_word      = $urandom();
    ver_word[7:0] = ver;
    wait_drained();
    put_reg(CFG_LEVEL, lvl_word);
    put_reg(CFG_HDR_WORDS, hdr);
    put_reg(CFG_VERSION, ver_word);
    cfg_close();
    cur_level = level;
    cur_hdr   = hdr;
    cur_ver   = ver;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_LEVEL;
    cfg_data  = '0;
    in_valid  = 1'b0;
    offer     = '0;
    jitter_on = 1'b1;
    hold_req  = 1'b0;
    sent      = 0;
    cur_level = LEVEL_RESET;
    cur_hdr   = HDR_WORDS_RESET;
    cur_ver   = VERSION_RESET;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      trk_time[i]   = {$urandom(), $urandom()};
      trk_frame[i]  = $urandom();
      trk_origin[i] = 16'($urandom());
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: only parse failures rejected, sequence faults only counted
    send_event(pin_event(6'd0, 24'd0, 1'b1, 32'd8, 8'd6, 64'd100, 16'h0000, 32'hFFFF_FFFF));
    send_event(pin_event(6'd0, 24'd5, 1'b1, 32'd8, 8'd6, 64'd200, 16'h0000, 32'd0));
    send_event(pin_event(6'd0, 24'hFF_FFFF, 1'b1, 32'd8, 8'd6, 64'd150, 16'h0000, 32'd1));
    send_event(pin_event(6'd0, 24'd3, 1'b1, 32'd8, 8'd6, 64'd300, 16'h0000, 32'd7));
    send_event(pin_event(6'd0, 24'd1, 1'b0, 32'd8, 8'd6, 64'd0, 16'h1234, 32'd99));
    send_event(pin_event(6'd0, 24'd2, 1'b1, 32'd8, 8'd6, 64'd400, 16'hFFFF, 32'd8));
    send_event(pin_event(6'd63, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_event(pin_event(6'd63, 24'd0, 1'b1, 32'd0, 8'd0, 64'd0, 16'hFFFF, 32'd0));
    send_event(pin_event(6'd1, 24'd9, 1'b0, 32'd8, 8'd6, 64'd50, 16'd5, 32'd10));
    send_event(pin_event(6'd1, 24'd9, 1'b1, 32'd8, 8'd6, 64'd50, 16'd9, 32'd10));

    // strict mode against the reset header length and version
    wait_drained();
    put_reg(CFG_LEVEL, {30'd0, LEVEL_STRICT});
    cfg_close();
    cur_level = LEVEL_STRICT;
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd6, 64'd10, 16'h00A5, 32'd50));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd9, 8'd6, 64'd11, 16'h00A5, 32'd51));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd7, 64'd12, 16'h00A5, 32'd52));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd0, 8'd0, 64'd13, 16'h00A5, 32'd53));
    send_event(pin_event(6'd2, 24'd40, 1'b0, 32'd0, 8'd0, 64'd14, 16'h00A5, 32'd54));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd6, 64'd5, 16'h00A5, 32'd51));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd6, 64'd20, 16'h00A5, 32'd60));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd6, 64'd1, 16'h00A5, 32'd90));
    send_event(pin_event(6'd2, 24'd40, 1'b1, 32'd8, 8'd6, 64'd30, 16'h00A5, 32'd91));

    // strict with extreme header length and version
    set_config(LEVEL_STRICT, 32'hFFFF_FFFF, 8'h00);
    send_event(pin_event(6'd3, 24'd7, 1'b1, 32'hFFFF_FFFF, 8'h00, 64'h8000_0000_0000_0000,
                         16'h8000, 32'h8000_0000));
    send_event(pin_event(6'd3, 24'd7, 1'b1, 32'd8, 8'd6, 64'h8000_0000_0000_0001,
                         16'h8000, 32'h8000_0001));
    directed = sent;

    // random phases over all levels; phase 2 runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config(2'd0, $urandom(), 8'($urandom()));
        1:       set_config(LEVEL_STRICT, 32'd0, 8'hFF);
        2:       set_config(2'd1, $urandom(), 8'($urandom()));
        3:       set_config(LEVEL_STRICT, 32'hFFFF_FFFF, 8'h00);
        4:       set_config(2'd3, $urandom(), 8'($urandom()));
        default: set_config(LEVEL_STRICT, $urandom(), 8'($urandom()));
      endcase
      jitter_on = (ph != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 50) hold_req = 1'b1;
        if (ph == 3 && k == 90) wait_drained();
        send_event(roll_event());
      end
    end

    // drain and settle
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("%0d events driven (%0d directed), %0d results checked, %0d rejected",
             sent, directed, checked, rejected);
    $display("levels 0 to 3, header and version extremes, result hold-off and drain pauses");
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
